@@ design/zlft_pkg.sv @@
`timescale 1ns / 1ps
package zlft_pkg;

	localparam int ZOOM_LEVELS_DEF = 32;
	localparam int CREDIT_W = 40;
	localparam int IDX_W = 64;
	localparam int THR_W = 16;
	localparam int QUOT_W = 33;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [CREDIT_W-1:0] CREDIT_ONE = 40'sd65536;
	localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = 40'sh7FFFFFFFFF;
	localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = 40'sh8000000000;
	localparam logic signed [CREDIT_W-1:0] CREDIT_INC_LIM = CREDIT_MAX - CREDIT_ONE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ZOOM     = 3'd0,
		REG_THIN_EN      = 3'd1,
		REG_LINE_DROP    = 3'd2,
		REG_POLY_DROP    = 3'd3,
		REG_DENSITY_THR  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_POINT   = 2'd0,
		KIND_LINE    = 2'd1,
		KIND_POLYGON = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	localparam logic ACT_FEATURE = 1'b0;
	localparam logic ACT_LOAD    = 1'b1;

	typedef struct packed {
		logic inc;
		logic load;
		logic step;
		logic tok_set;
		logic tok_clr;
		logic mark;
	} cell_ctl_t;

endpackage

@@ design/zlft_cell.sv @@
`timescale 1ns / 1ps
module zlft_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  zlft_pkg::cell_ctl_t                  ctl,
	input  logic [zlft_pkg::CREDIT_W-1:0]        ival,
	input  logic [zlft_pkg::IDX_W-1:0]           idx,
	input  logic                                 tok_in,
	output logic                                 tok_out,
	output logic                                 neg,
	output logic [zlft_pkg::IDX_W-1:0]           last_kept
);
	logic signed [zlft_pkg::CREDIT_W-1:0] credit_q;
	logic [zlft_pkg::CREDIT_W-1:0] interval_q;
	logic [zlft_pkg::IDX_W-1:0] lk_q;
	logic tok_q;
	logic signed [zlft_pkg::CREDIT_W:0] diff;

	assign diff = {credit_q[zlft_pkg::CREDIT_W-1], credit_q} - {1'b0, interval_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			interval_q <= '0;
			lk_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (ctl.load)
				interval_q <= ival;
			if (ctl.inc) begin
				if (credit_q > zlft_pkg::CREDIT_INC_LIM)
					credit_q <= zlft_pkg::CREDIT_MAX;
				else
					credit_q <= credit_q + zlft_pkg::CREDIT_ONE;
			end else if (ctl.step && tok_q) begin
				// saturate at the most negative value
				if (diff[zlft_pkg::CREDIT_W] && !diff[zlft_pkg::CREDIT_W-1])
					credit_q <= zlft_pkg::CREDIT_MIN;
				else
					credit_q <= diff[zlft_pkg::CREDIT_W-1:0];
			end
			if (ctl.mark)
				lk_q <= idx;
			if (ctl.tok_set)
				tok_q <= 1'b1;
			else if (ctl.tok_clr)
				tok_q <= 1'b0;
			else if (ctl.step)
				tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
	assign neg = tok_q & credit_q[zlft_pkg::CREDIT_W-1];
	assign last_kept = lk_q;
endmodule

@@ design/zlft_div.sv @@
`timescale 1ns / 1ps
module zlft_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [zlft_pkg::THR_W-1:0]        divisor,
	output logic                              running,
	output logic                              valid,
	output logic [zlft_pkg::QUOT_W-1:0]       quot
);
	// restoring divide of 2^32 by the divisor, one quotient bit a cycle
	localparam int CNT_W = $clog2(zlft_pkg::QUOT_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [zlft_pkg::THR_W:0] rem_q;
	logic [zlft_pkg::QUOT_W-1:0] quot_q;
	logic [zlft_pkg::THR_W-1:0] dvs_q;
	logic run_q, valid_q;
	logic [zlft_pkg::THR_W:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q[zlft_pkg::THR_W-1:0], (cnt_q == CNT_W'(zlft_pkg::QUOT_W))};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			valid_q <= 1'b0;
			cnt_q <= CNT_W'(zlft_pkg::QUOT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quot_q <= {quot_q[zlft_pkg::QUOT_W-2:0], ge};
		end
	end

	assign running = run_q;
	assign valid = valid_q;
	assign quot = quot_q;
endmodule

@@ design/zoom_level_feature_thinning.sv @@
`timescale 1ns / 1ps
// Zoom-level feature thinning. A load item (action 1) writes one zoom's drop interval and
// gives no result. A feature item returns one min_zoom on the done strobe, shown for
// exactly one cycle; the receiver cannot stall it. Items not thinned answer in the cycle
// after the transfer. A thinned feature raises the credits of zooms 0 to the clamped
// max_zoom at the transfer, then a token walks down the chain of zoom cells one cell a
// cycle; with a nonzero density threshold each zoom checked passes through S_DENS_A, where
// the 32x32 square of the gap limit is registered, and then S_DENS_B for the 64-bit compare;
// S_DENS_A ends the check when no zoom is taken, and the check waits for the serial divider
// started at the transfer. S_MARK then writes the last-kept indexes and shows the result.
// busy is high from the transfer until the divider and the result are done.
module zoom_level_feature_thinning #(
	parameter int ZOOM_LEVELS = zlft_pkg::ZOOM_LEVELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  action,
	input  logic [1:0]                            feature_kind,
	input  logic [zlft_pkg::IDX_W-1:0]            feature_index,
	input  logic [4:0]                            zoom_select,
	input  logic [zlft_pkg::CREDIT_W-1:0]         interval_value,
	output logic                                  done,
	output logic [5:0]                            min_zoom,
	input  logic                                  wr_en,
	input  logic [zlft_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [zlft_pkg::THR_W-1:0]            wr_data
);
	localparam int ZW = (ZOOM_LEVELS > 1) ? $clog2(ZOOM_LEVELS) : 1;
	localparam logic [5:0] LEVELS6 = 6'(ZOOM_LEVELS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_WALK   = 5'b00010,
		S_DENS_A = 5'b00100,
		S_DENS_B = 5'b01000,
		S_MARK   = 5'b10000
	} state_t;

	state_t state_q;

	logic [4:0] max_zoom_q;
	logic thin_en_q, line_q, poly_q;
	logic [zlft_pkg::THR_W-1:0] thr_q;

	logic [zlft_pkg::IDX_W-1:0] idx_q;
	logic [ZW-1:0] top_q, pos_q;
	logic [5:0] chosen_q, res_q, lo_q, dz_q;
	logic mark_en_q;
	logic done_q;
	logic [5:0] min_zoom_q;
	logic [63:0] lim_s1, gap_s1;

	logic accept, thin_w, hold, go_div;
	logic [4:0] top_cl;
	logic [ZW-1:0] top_z;
	logic div_run, div_valid;
	logic [zlft_pkg::QUOT_W-1:0] q0;
	logic [zlft_pkg::QUOT_W-1:0] q_sh;

	zlft_pkg::cell_ctl_t ctl [ZOOM_LEVELS];
	logic [ZOOM_LEVELS-1:0] tok_vec, neg_vec;
	logic [ZOOM_LEVELS:0] tok_chain;
	logic [zlft_pkg::IDX_W-1:0] lk_vec [ZOOM_LEVELS];

	assign busy = (state_q != S_IDLE) || div_run;
	assign accept = start && !busy;
	assign top_cl = ({1'b0, max_zoom_q} >= LEVELS6) ? 5'(ZOOM_LEVELS - 1) : max_zoom_q;
	assign top_z = top_cl[ZW-1:0];
	assign thin_w = thin_en_q && ((feature_kind == zlft_pkg::KIND_POINT) ||
		(feature_kind == zlft_pkg::KIND_LINE && line_q) ||
		(feature_kind == zlft_pkg::KIND_POLYGON && poly_q));
	assign go_div = accept && action == zlft_pkg::ACT_FEATURE && thin_w && thr_q != '0;
	assign hold = |neg_vec;
	assign q_sh = q0 >> dz_q[ZW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_zoom_q <= 5'd14;
			thin_en_q <= 1'b1;
			line_q <= 1'b0;
			poly_q <= 1'b0;
			thr_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				zlft_pkg::REG_MAX_ZOOM:    max_zoom_q <= wr_data[4:0];
				zlft_pkg::REG_THIN_EN:     thin_en_q <= wr_data[0];
				zlft_pkg::REG_LINE_DROP:   line_q <= wr_data[0];
				zlft_pkg::REG_POLY_DROP:   poly_q <= wr_data[0];
				zlft_pkg::REG_DENSITY_THR: thr_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			min_zoom_q <= '0;
			mark_en_q <= 1'b0;
			pos_q <= '0;
			top_q <= '0;
			dz_q <= '0;
			chosen_q <= '0;
			res_q <= '0;
			lo_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && action == zlft_pkg::ACT_FEATURE) begin
						if (thin_w) begin
							top_q <= top_z;
							pos_q <= top_z;
							mark_en_q <= 1'b0;
							state_q <= S_WALK;
						end else begin
							done_q <= 1'b1;
							min_zoom_q <= '0;
						end
					end
				end
				S_WALK: begin
					dz_q <= '0;
					if (hold || pos_q == '0) begin
						if (hold) begin
							chosen_q <= 6'(pos_q) + 6'd1;
							res_q <= 6'(pos_q) + 6'd1;
							lo_q <= 6'(pos_q) + 6'd1;
							mark_en_q <= 1'b1;
						end else begin
							chosen_q <= 6'(top_q) + 6'd1;
							res_q <= '0;
						end
						state_q <= (thr_q != '0) ? S_DENS_A : S_MARK;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				S_DENS_A: begin
					if (!(dz_q < chosen_q && dz_q < 6'(top_q)))
						state_q <= S_MARK;
					else if (div_valid)
						state_q <= S_DENS_B;
				end
				S_DENS_B: begin
					if (gap_s1 > lim_s1) begin
						res_q <= dz_q;
						lo_q <= dz_q;
						mark_en_q <= 1'b1;
						state_q <= S_MARK;
					end else begin
						dz_q <= dz_q + 6'd1;
						state_q <= S_DENS_A;
					end
				end
				S_MARK: begin
					done_q <= 1'b1;
					min_zoom_q <= res_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			idx_q <= feature_index;
		// limit squared, saturated when the shifted quotient needs 33 bits
		lim_s1 <= q_sh[32] ? '1 : {32'd0, q_sh[31:0]} * {32'd0, q_sh[31:0]};
		gap_s1 <= idx_q - lk_vec[dz_q[ZW-1:0]];
	end

	zlft_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go_div),
		.divisor (thr_q),
		.running (div_run),
		.valid   (div_valid),
		.quot    (q0)
	);

	assign tok_chain[ZOOM_LEVELS] = 1'b0;

	for (genvar g = 0; g < ZOOM_LEVELS; g++) begin : g_cell
		always_comb begin
			ctl[g].inc = accept && action == zlft_pkg::ACT_FEATURE && thin_w &&
				(6'(g) <= {1'b0, top_cl});
			ctl[g].load = accept && action == zlft_pkg::ACT_LOAD && zoom_select == 5'(g);
			ctl[g].tok_set = accept && action == zlft_pkg::ACT_FEATURE && thin_w &&
				(6'(g) == {1'b0, top_cl});
			ctl[g].step = (state_q == S_WALK) && !hold;
			ctl[g].tok_clr = (state_q == S_MARK);
			ctl[g].mark = (state_q == S_MARK) && mark_en_q && (lo_q <= 6'(g)) &&
				(6'(g) <= 6'(top_q));
		end

		zlft_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[g]),
			.ival      (interval_value),
			.idx       (idx_q),
			.tok_in    (tok_chain[g+1]),
			.tok_out   (tok_vec[g]),
			.neg       (neg_vec[g]),
			.last_kept (lk_vec[g])
		);
		assign tok_chain[g] = tok_vec[g];
	end

	assign done = done_q;
	assign min_zoom = min_zoom_q;

	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec)) else $error("more than one walk token");
	a_tok_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> tok_vec[pos_q]) else $error("token not at walk position");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_MARK || $past(accept)))
		else $error("result without a source");
	a_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_zoom <= {1'b0, top_cl} + 6'd1)) else $error("min_zoom out of range");
endmodule
